// ===== rtl/ctb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Contact tangent basis package
// Shared widths, transaction types and fixed-point helpers for the tangent
// basis pipeline.
// ----------------------------------------------------------------------------
package ctb_pkg;

   // Fixed-point format of every vector component
   localparam int FRAC_BITS = 14;
   localparam int IN_W      = 16;
   localparam int OUT_W     = 16;
   localparam int MARGIN_W  = 15;
   localparam int ONE       = 1 << FRAC_BITS;

   // Saturated component width, margin compare width
   localparam int ONE_W = FRAC_BITS + 2;
   localparam int GAP_W = IN_W + 3;

   // Planar length: s = nx^2 + ny^2, root of s * 2^16
   localparam int ROOT_SHIFT = 16;
   localparam int S_W        = 2 * IN_W;
   localparam int V_W        = S_W + ROOT_SHIFT;
   localparam int L_W        = V_W / 2;

   // Rounded divide |n| * ONE * 256 / L
   localparam int MAG_W   = IN_W + 1;
   localparam int N_W     = MAG_W + FRAC_BITS + 8;
   localparam int NUM_W   = N_W + 2;
   localparam int DEN_W   = L_W + 1;
   localparam int Q_W     = FRAC_BITS + 2;
   localparam int R_W     = NUM_W + 1;

   // Cross product widths
   localparam int P_W  = ONE_W + IN_W;
   localparam int D_W  = P_W + 1;
   localparam int CL_W = ONE_W + OUT_W;

   // Accept edge to result strobe, in clock cycles
   localparam int LAT = L_W + Q_W + 6;

   localparam logic signed [OUT_W-1:0] ONE_OUT = OUT_W'(ONE);
   localparam logic signed [D_W:0]     ONE_WIDE = (D_W + 1)'(ONE);
   localparam logic signed [CL_W-1:0]  OUT_MAX = CL_W'((1 << (OUT_W - 1)) - 1);
   localparam logic signed [CL_W-1:0]  OUT_MIN = -CL_W'(1 << (OUT_W - 1));

   typedef enum logic [1:0] {
      MODE_GENERAL,
      MODE_POLE_POS,
      MODE_POLE_NEG,
      MODE_DEGEN
   } basis_mode_type;

   typedef struct packed {
      logic signed [IN_W-1:0] normal_x;
      logic signed [IN_W-1:0] normal_y;
      logic signed [IN_W-1:0] normal_z;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] tangent_a_x;
      logic signed [OUT_W-1:0] tangent_a_y;
      logic signed [OUT_W-1:0] tangent_a_z;
      logic signed [OUT_W-1:0] tangent_b_x;
      logic signed [OUT_W-1:0] tangent_b_y;
      logic signed [OUT_W-1:0] tangent_b_z;
      logic                    degenerate;
   } rsp_type;

   typedef struct packed {
      logic           valid;
      basis_mode_type mode;
      req_type        req;
   } side_type;

   // Clamp to [-ONE, ONE]
   function automatic logic signed [ONE_W-1:0] sat_unit(input logic signed [D_W:0] v);
      logic signed [D_W:0] r;
      if (v > ONE_WIDE) begin
         r = ONE_WIDE;
      end else if (v < -ONE_WIDE) begin
         r = -ONE_WIDE;
      end else begin
         r = v;
      end
      return ONE_W'(r);
   endfunction

   // Scale by 2^-FRAC_BITS, round to nearest, ties away from zero
   function automatic logic signed [D_W:0] scale_down(input logic signed [D_W-1:0] p);
      logic           neg;
      logic [D_W-1:0] mag;
      logic [D_W:0]   sum;
      logic [D_W:0]   q;
      neg = p[D_W-1];
      mag = neg ? D_W'(-p) : D_W'(p);
      sum = {1'b0, mag} + (D_W + 1)'(1 << (FRAC_BITS - 1));
      q   = sum >> FRAC_BITS;
      return neg ? -$signed(q) : $signed(q);
   endfunction

   // Clamp to the output field range
   function automatic logic signed [OUT_W-1:0] to_out(input logic signed [ONE_W-1:0] v);
      logic signed [CL_W-1:0] e;
      logic signed [CL_W-1:0] r;
      e = CL_W'(v);
      if (e > OUT_MAX) begin
         r = OUT_MAX;
      end else if (e < OUT_MIN) begin
         r = OUT_MIN;
      end else begin
         r = e;
      end
      return OUT_W'(r);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/contact_tangent_basis_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Contact tangent basis
// Two orthogonal unit tangents for a unit contact normal, Q1.14.
// ----------------------------------------------------------------------------
// One normal is taken every clock (busy stays low) and each result appears on
// rsp_strobe after its start edge, in order. The pipeline depth is set by the
// 24-stage square root of the planar length and the 16-stage dividers that
// normalize the tangent; a few more stages square the inputs, pick the pole
// case and form the cross product. The receiver takes each result in the cycle
// it is shown. Write pole_margin only while no transaction is in flight.
module contact_tangent_basis_top (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire ctb_pkg::req_type          req_data,
   output logic                           rsp_strobe,
   output ctb_pkg::rsp_type               rsp_data,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [ctb_pkg::MARGIN_W-1:0] csr_data
);
   import ctb_pkg::*;

   logic [MARGIN_W-1:0] margin_ff;

   side_type            a_ff;
   logic [S_W-1:0]      sqx_ff, sqy_ff;
   side_type            b_ff;
   logic [V_W-1:0]      v_ff;
   side_type            sd1_ff [0:L_W-1];
   logic [L_W-1:0]      root;
   side_type            c_ff;
   logic [NUM_W-1:0]    num_a_ff, num_b_ff;
   logic [DEN_W-1:0]    den_ff;
   side_type            sd2_ff [0:Q_W-1];
   logic [Q_W-1:0]      quot_a, quot_b;
   side_type            d_ff;
   logic signed [ONE_W-1:0] ax_ff, ay_ff, ax_in, ay_in;
   logic                e_valid_ff;
   basis_mode_type      e_mode_ff;
   logic signed [ONE_W-1:0] e_ax_ff, e_ay_ff;
   logic signed [P_W-1:0]   p_aynz_ff, p_axnz_ff, p_axny_ff, p_aynx_ff;
   logic                f_valid_ff;
   rsp_type             f_rsp_ff, f_rsp_in;
   basis_mode_type      mode_in;

   logic signed [GAP_W-1:0] gap_pos, gap_neg, margin_s;
   logic signed [S_W-1:0]   ex_x, ex_y;
   logic signed [MAG_W-1:0] ext_x, ext_y;
   logic [MAG_W-1:0]        mag_x, mag_y;
   logic signed [D_W:0]     qa_s, qb_s;
   logic                    neg_b;
   logic signed [P_W-1:0]   ex_ax, ex_ay, ex_nx, ex_ny, ex_nz;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Hold the pole margin
   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_W'(1);
      end else if (csr_valid && csr_ready) begin
         margin_ff <= csr_data;
      end
   end

   // Classify the normal: poles first, then zero planar length
   always_comb begin
      margin_s = GAP_W'(margin_ff);
      gap_pos  = GAP_W'(ONE) - GAP_W'(req_data.normal_z);
      gap_neg  = GAP_W'(ONE) + GAP_W'(req_data.normal_z);
      priority if (gap_pos < margin_s) begin
         mode_in = MODE_POLE_POS;
      end else if (gap_neg < margin_s) begin
         mode_in = MODE_POLE_NEG;
      end else if (req_data.normal_x == '0 && req_data.normal_y == '0) begin
         mode_in = MODE_DEGEN;
      end else begin
         mode_in = MODE_GENERAL;
      end
   end

   assign ex_x = S_W'(req_data.normal_x);
   assign ex_y = S_W'(req_data.normal_y);

   // Stage A: capture, square the planar components
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
      end else begin
         a_ff.valid <= start && !busy;
      end
      a_ff.mode <= mode_in;
      a_ff.req  <= req_data;
      sqx_ff    <= S_W'(ex_x * ex_x);
      sqy_ff    <= S_W'(ex_y * ex_y);
   end

   // Stage B: planar length squared, scaled for the root
   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff.valid <= 1'b0;
      end else begin
         b_ff.valid <= a_ff.valid;
      end
      b_ff.mode <= a_ff.mode;
      b_ff.req  <= a_ff.req;
      v_ff      <= {sqx_ff + sqy_ff, ROOT_SHIFT'(0)};
   end

   ctb_sqrt u_sqrt (
      .clock (clock),
      .v_in  (v_ff),
      .root  (root)
   );

   // Advance the side data alongside the root stages
   for (genvar j = 0; j < L_W; j++) begin : g_sd1
      always_ff @(posedge clock) begin
         if (reset) begin
            sd1_ff[j].valid <= 1'b0;
         end else begin
            sd1_ff[j].valid <= (j == 0) ? b_ff.valid : sd1_ff[(j == 0) ? 0 : j-1].valid;
         end
         sd1_ff[j].mode <= (j == 0) ? b_ff.mode : sd1_ff[(j == 0) ? 0 : j-1].mode;
         sd1_ff[j].req  <= (j == 0) ? b_ff.req  : sd1_ff[(j == 0) ? 0 : j-1].req;
      end
   end

   // Magnitudes of the planar components
   always_comb begin
      ext_x = MAG_W'(sd1_ff[L_W-1].req.normal_x);
      ext_y = MAG_W'(sd1_ff[L_W-1].req.normal_y);
      mag_x = (ext_x < 0) ? MAG_W'(-ext_x) : MAG_W'(ext_x);
      mag_y = (ext_y < 0) ? MAG_W'(-ext_y) : MAG_W'(ext_y);
   end

   // Stage C: rounded-divide operands (2n + L) / 2L
   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff.valid <= 1'b0;
      end else begin
         c_ff.valid <= sd1_ff[L_W-1].valid;
      end
      c_ff.mode <= sd1_ff[L_W-1].mode;
      c_ff.req  <= sd1_ff[L_W-1].req;
      num_a_ff  <= (NUM_W'(mag_y) << (FRAC_BITS + 9)) + NUM_W'(root);
      num_b_ff  <= (NUM_W'(mag_x) << (FRAC_BITS + 9)) + NUM_W'(root);
      den_ff    <= {root, 1'b0};
   end

   ctb_div u_div_a (
      .clock (clock),
      .num   (num_a_ff),
      .den   (den_ff),
      .quot  (quot_a)
   );

   ctb_div u_div_b (
      .clock (clock),
      .num   (num_b_ff),
      .den   (den_ff),
      .quot  (quot_b)
   );

   // Advance the side data alongside the divide stages
   for (genvar k = 0; k < Q_W; k++) begin : g_sd2
      always_ff @(posedge clock) begin
         if (reset) begin
            sd2_ff[k].valid <= 1'b0;
         end else begin
            sd2_ff[k].valid <= (k == 0) ? c_ff.valid : sd2_ff[(k == 0) ? 0 : k-1].valid;
         end
         sd2_ff[k].mode <= (k == 0) ? c_ff.mode : sd2_ff[(k == 0) ? 0 : k-1].mode;
         sd2_ff[k].req  <= (k == 0) ? c_ff.req  : sd2_ff[(k == 0) ? 0 : k-1].req;
      end
   end

   // Sign, saturate and select the first tangent
   always_comb begin
      qa_s  = (D_W + 1)'(quot_a);
      qb_s  = (D_W + 1)'(quot_b);
      neg_b = !sd2_ff[Q_W-1].req.normal_x[IN_W-1] && (sd2_ff[Q_W-1].req.normal_x != '0);
      unique case (sd2_ff[Q_W-1].mode)
         MODE_GENERAL: begin
            ax_in = sat_unit(sd2_ff[Q_W-1].req.normal_y[IN_W-1] ? -qa_s : qa_s);
            ay_in = sat_unit(neg_b ? -qb_s : qb_s);
         end
         MODE_POLE_NEG: begin
            ax_in = -ONE_W'(ONE);
            ay_in = '0;
         end
         MODE_POLE_POS, MODE_DEGEN: begin
            ax_in = ONE_W'(ONE);
            ay_in = '0;
         end
      endcase
   end

   // Stage D: first tangent
   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff.valid <= 1'b0;
      end else begin
         d_ff.valid <= sd2_ff[Q_W-1].valid;
      end
      d_ff.mode <= sd2_ff[Q_W-1].mode;
      d_ff.req  <= sd2_ff[Q_W-1].req;
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
   end

   assign ex_ax = P_W'(ax_ff);
   assign ex_ay = P_W'(ay_ff);
   assign ex_nx = P_W'(d_ff.req.normal_x);
   assign ex_ny = P_W'(d_ff.req.normal_y);
   assign ex_nz = P_W'(d_ff.req.normal_z);

   // Stage E: cross product terms
   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= d_ff.valid;
      end
      e_mode_ff <= d_ff.mode;
      e_ax_ff   <= ax_ff;
      e_ay_ff   <= ay_ff;
      p_aynz_ff <= P_W'(ex_ay * ex_nz);
      p_axnz_ff <= P_W'(ex_ax * ex_nz);
      p_axny_ff <= P_W'(ex_ax * ex_ny);
      p_aynx_ff <= P_W'(ex_ay * ex_nx);
   end

   // Scale, round and saturate the second tangent
   always_comb begin
      f_rsp_in.tangent_a_x = to_out(e_ax_ff);
      f_rsp_in.tangent_a_y = to_out(e_ay_ff);
      f_rsp_in.tangent_a_z = '0;
      f_rsp_in.tangent_b_x = to_out(sat_unit(scale_down(D_W'(p_aynz_ff))));
      f_rsp_in.tangent_b_y = to_out(sat_unit(scale_down(-D_W'(p_axnz_ff))));
      f_rsp_in.tangent_b_z = to_out(sat_unit(scale_down(D_W'(p_axny_ff) - D_W'(p_aynx_ff))));
      f_rsp_in.degenerate  = (e_mode_ff == MODE_DEGEN);
   end

   // Stage F: result register
   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= e_valid_ff;
      end
      f_rsp_ff <= f_rsp_in;
   end

   assign rsp_strobe = f_valid_ff;
   assign rsp_data   = f_rsp_ff;

`ifndef SYNTHESIS
   // Every accepted transaction comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_strobe)
      else $error("result missing at fixed latency");

   // No result without a transaction accepted the fixed latency earlier
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("result without accepted transaction");

   // Degenerate normals give the x axis as first tangent
   a_degen_axis: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.degenerate) |->
         (rsp_data.tangent_a_x == ONE_OUT && rsp_data.tangent_a_y == '0))
      else $error("degenerate result with wrong tangent");

   // Second tangent stays within the unit range
   a_b_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |->
         (rsp_data.tangent_b_x <= ONE_OUT && rsp_data.tangent_b_x >= -ONE_OUT &&
          rsp_data.tangent_b_y <= ONE_OUT && rsp_data.tangent_b_y >= -ONE_OUT &&
          rsp_data.tangent_b_z <= ONE_OUT && rsp_data.tangent_b_z >= -ONE_OUT))
      else $error("second tangent out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/ctb_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per register stage; floor(sqrt(v_in)) leaves the last stage.
// ----------------------------------------------------------------------------
module ctb_sqrt (
   input  wire logic                  clock,
   input  wire logic [ctb_pkg::V_W-1:0] v_in,
   output logic      [ctb_pkg::L_W-1:0] root
);
   import ctb_pkg::*;

   logic [V_W-1:0] rem_ff [0:L_W-1];
   logic [V_W-1:0] res_ff [0:L_W-1];

   for (genvar j = 0; j < L_W; j++) begin : g_step
      localparam logic [V_W-1:0] BIT = V_W'(1) << (V_W - 2 - 2 * j);
      logic [V_W-1:0] rem_prev;
      logic [V_W-1:0] res_prev;
      logic [V_W-1:0] trial;
      logic [V_W-1:0] rem_in;
      logic [V_W-1:0] res_in;

      // Take the previous stage, or the operand at the first step
      if (j == 0) begin : g_first
         assign rem_prev = v_in;
         assign res_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign res_prev = res_ff[j-1];
      end

      // Try one root bit
      always_comb begin
         trial = res_prev + BIT;
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            res_in = (res_prev >> 1) + BIT;
         end else begin
            rem_in = rem_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[j] <= rem_in;
         res_ff[j] <= res_in;
      end
   end

   assign root = res_ff[L_W-1][L_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/ctb_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage; quotient must fit in Q_W bits.
// ----------------------------------------------------------------------------
module ctb_div (
   input  wire logic                      clock,
   input  wire logic [ctb_pkg::NUM_W-1:0] num,
   input  wire logic [ctb_pkg::DEN_W-1:0] den,
   output logic      [ctb_pkg::Q_W-1:0]   quot
);
   import ctb_pkg::*;

   logic [R_W-1:0]   rem_ff [0:Q_W-1];
   logic [DEN_W-1:0] den_ff [0:Q_W-1];
   logic [Q_W-1:0]   q_ff   [0:Q_W-1];

   for (genvar k = 0; k < Q_W; k++) begin : g_step
      localparam int SH = Q_W - 1 - k;
      logic [R_W-1:0]   rem_prev;
      logic [DEN_W-1:0] den_prev;
      logic [Q_W-1:0]   q_prev;
      logic [R_W-1:0]   dsh;
      logic [R_W-1:0]   rem_in;
      logic [Q_W-1:0]   q_in;

      if (k == 0) begin : g_first
         assign rem_prev = R_W'(num);
         assign den_prev = den;
         assign q_prev   = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign q_prev   = q_ff[k-1];
      end

      // Subtract the shifted divisor when it fits
      always_comb begin
         dsh  = R_W'(den_prev) << SH;
         q_in = q_prev;
         if (rem_prev >= dsh) begin
            rem_in   = rem_prev - dsh;
            q_in[SH] = 1'b1;
         end else begin
            rem_in = rem_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         den_ff[k] <= den_prev;
         q_ff[k]   <= q_in;
      end
   end

   assign quot = q_ff[Q_W-1];

endmodule
`default_nettype wire

// ===== verif/contact_tangent_basis_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Contact tangent basis testbench
// Feeds contact normals through the command port and checks every tangent
// pair against a predictor of the fixed-point basis, under several
// pole_margin settings and start idling patterns.
// ----------------------------------------------------------------------------
module contact_tangent_basis_top_test;
   import ctb_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [MARGIN_W-1:0] csr_data;

   req_type   pending_normals[$];
   rsp_type   expected_bases[$];
   logic [MARGIN_W-1:0] margin_now;
   int        idle_pct;
   int        fail_count;
   logic      csr_pending;
   logic [MARGIN_W-1:0] csr_value;
   logic      hold_send;

   contact_tangent_basis_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("** contact_tangent_basis_top: FAILED **");
      $finish;
   end

   // Integer square root, floor
   function automatic longint unsigned root_floor(input longint unsigned v);
      longint unsigned res;
      longint unsigned bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v = v - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   function automatic longint clamp_unit(input longint v);
      if (v > ONE) return ONE;
      if (v < -ONE) return -ONE;
      return v;
   endfunction

   function automatic longint round_shift(input longint p);
      longint unsigned m;
      longint q;
      m = (p < 0) ? -p : p;
      q = (m + (1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return (p < 0) ? -q : q;
   endfunction

   function automatic longint unit_divide(input longint num, input longint unsigned len);
      longint unsigned m;
      longint unsigned n;
      longint q;
      m = (num < 0) ? -num : num;
      n = (m << FRAC_BITS) << 8;
      q = (2 * n + len) / (2 * len);
      return (num < 0) ? -q : q;
   endfunction

   function automatic logic signed [15:0] to_field(input longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   // Predict the tangent pair for one normal
   function automatic rsp_type tangent_basis(input req_type n, input longint margin);
      longint nx, ny, nz, ax, ay;
      longint unsigned s;
      rsp_type r;
      nx = n.normal_x; ny = n.normal_y; nz = n.normal_z;
      r = '0;
      if (ONE - nz < margin) begin
         ax = ONE; ay = 0;
      end else if (ONE + nz < margin) begin
         ax = -ONE; ay = 0;
      end else begin
         s = nx * nx + ny * ny;
         if (s == 0) begin
            ax = ONE; ay = 0; r.degenerate = 1'b1;
         end else begin
            ax = clamp_unit(unit_divide(ny, root_floor(s << 16)));
            ay = clamp_unit(unit_divide(-nx, root_floor(s << 16)));
         end
      end
      r.tangent_a_x = to_field(ax);
      r.tangent_a_y = to_field(ay);
      r.tangent_b_x = to_field(clamp_unit(round_shift(ay * nz)));
      r.tangent_b_y = to_field(clamp_unit(round_shift(-(ax * nz))));
      r.tangent_b_z = to_field(clamp_unit(round_shift(ax * ny - ay * nx)));
      return r;
   endfunction

   // Drive normals from the pending queue, predicting at acceptance
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_bases.push_back(tangent_basis(req_data, margin_now));
         end
         if ((start && !busy) || !start) begin
            if (pending_normals.size() != 0 && !hold_send &&
                $urandom_range(99) >= idle_pct) begin
               start <= 1'b1;
               req_data <= pending_normals.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Write the margin register when asked
   always @(posedge clock) begin
      if (reset) begin
         csr_valid <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         margin_now <= csr_data;
         csr_valid <= 1'b0;
         csr_pending <= 1'b0;
      end else if (csr_pending && !csr_valid) begin
         csr_valid <= 1'b1;
         csr_data <= csr_value;
      end
   end

   // Compare each strobed result with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_bases.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            fail_count = fail_count + 1;
         end else begin
            want = expected_bases.pop_front();
            if (want != rsp_data) begin
               $display("%0t: mismatch expected %h actual %h", $time, want, rsp_data);
               fail_count = fail_count + 1;
            end
         end
      end
   end

   function automatic logic signed [15:0] any_component();
      case ($urandom_range(5))
         0: return 16'(ONE);
         1: return -16'(ONE);
         2: return 16'($urandom);
         3: return 16'($signed($urandom_range(2 * ONE)) - ONE);
         4: return 16'($signed($urandom_range(40)) - 20);
         default: return 16'(ONE - $urandom_range(60));
      endcase
   endfunction

   task automatic drain();
      while (pending_normals.size() != 0 || start || expected_bases.size() != 0)
         @(posedge clock);
      repeat (LAT + 4) @(posedge clock);
   endtask

   task automatic write_margin(input logic [MARGIN_W-1:0] v);
      csr_value = v;
      csr_pending = 1'b1;
      while (csr_pending) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic add_normal(input int x, input int y, input int z);
      req_type n;
      n.normal_x = 16'(x); n.normal_y = 16'(y); n.normal_z = 16'(z);
      pending_normals.push_back(n);
   endtask

   initial begin
      req_type n;
      logic [MARGIN_W-1:0] margins[5];
      int mg;
      fail_count = 0;
      idle_pct = 0;
      hold_send = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      csr_pending = 1'b0;
      csr_value = '0;
      margin_now = 1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: poles, degenerate, extremes of the fields
      add_normal(0, 0, ONE);
      add_normal(0, 0, -ONE);
      add_normal(0, 0, 0);
      add_normal(ONE, 0, 0);
      add_normal(0, ONE, 0);
      add_normal(-ONE, 0, 0);
      add_normal(0, -ONE, 0);
      add_normal(11585, 11585, 0);
      add_normal(-32768, -32768, -32768);
      add_normal(32767, 32767, 32767);
      add_normal(32767, -32768, 0);
      add_normal(1, 0, 100);
      add_normal(0, -1, -100);
      add_normal(9459, 9459, 9459);
      add_normal(100, 200, ONE - 1);
      add_normal(-3, 4, -ONE + 1);
      drain();

      margins[0] = 0;
      margins[1] = 16384;
      margins[2] = 15'h7FFF;
      margins[3] = 50;
      margins[4] = 1;
      for (int ph = 0; ph < 5; ph++) begin
         write_margin(margins[ph]);
         // Margin-edge normals for this setting
         mg = margins[ph];
         add_normal(5, 7, ONE - mg);
         add_normal(5, 7, ONE - mg + 1);
         add_normal(0, 0, -ONE + mg - 1);
         for (int k = 0; k < 190; k++) begin
            n.normal_x = any_component();
            n.normal_y = any_component();
            n.normal_z = any_component();
            pending_normals.push_back(n);
         end
         case (ph)
            0: idle_pct = 0;
            1: idle_pct = 60;
            2: idle_pct = 9;
            3: idle_pct = 60;
            default: idle_pct = 0;
         endcase
         // Hold off mid-phase until every result is back
         while (pending_normals.size() > 95) @(posedge clock);
         hold_send = 1'b1;
         @(posedge clock);
         while (start || expected_bases.size() != 0) @(posedge clock);
         hold_send = 1'b0;
         drain();
      end

      if (fail_count == 0) begin
         $display("** contact_tangent_basis_top: PASSED **");
      end else begin
         $display("** contact_tangent_basis_top: FAILED **");
      end
      $finish;
   end

endmodule
